/* src/esc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants of the edge sort / csr builder
// Request and response layouts, function and status codes, key helper.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned DEF_MAX_EDGES = 256;
  localparam int unsigned MAX_NODES     = 1024;
  localparam int unsigned NUM_SWITCHES  = 64;

  localparam int unsigned NODE_W  = 10;
  localparam int unsigned SW_W    = 6;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned MASK_W  = 64;
  localparam int unsigned KEY_W   = 2 * NODE_W + SW_W + 1;
  localparam int unsigned PADDR_W = 4;

  localparam logic [MASK_W-1:0] MASK_RESET       = {MASK_W{1'b1}};
  localparam logic [IDX_W-1:0]  NODE_COUNT_RESET = IDX_W'(1024);

  // register select bit of paddr (registers at byte 0 and byte 8)
  localparam logic REG_MASK  = 1'b0;
  localparam logic REG_NODES = 1'b1;

  localparam logic [1:0] FUNC_INSERT      = 2'd0;
  localparam logic [1:0] FUNC_READ_EDGE   = 2'd1;
  localparam logic [1:0] FUNC_READ_OFFSET = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_LOCKED = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [SW_W-1:0]   switch_id;
    logic [IDX_W-1:0]  index;
  } esc_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [NODE_W-1:0] edge_src;
    logic [NODE_W-1:0] edge_dest;
    logic [SW_W-1:0]   edge_sw;
    logic [CNT_W-1:0]  first_offset;
    logic [CNT_W-1:0]  edge_total;
  } esc_rsp_t;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dest;
    logic [SW_W-1:0]   sw;
  } esc_edge_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              start;
    logic              step;
    logic              stop;
    logic              place;
    logic [1:0]        func;
    esc_edge_t         ins_edge;
    logic [IDX_W-1:0]  idx;
    logic [MASK_W-1:0] mask;
  } esc_ctrl_t;

  function automatic logic [KEY_W-1:0] edge_key(input logic [MASK_W-1:0] mask,
                                                input esc_edge_t e);
    logic nonconf;
    nonconf = 1'b1;
    if (({1'b0, e.sw} < (SW_W + 1)'(NUM_SWITCHES)) && mask[e.sw]) begin
      nonconf = 1'b0;
    end
    return {e.src, nonconf, e.dest, e.sw};
  endfunction

endpackage
`default_nettype wire

/* src/edge_sort_csr_builder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edge_sort_csr_builder_unit: sorted edge table with csr offsets
// Keeps edges in key order in a chain of cells and answers index queries.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a clock edge where start is high and busy is low.
//   req_i.func selects insert, read of the sorted edge at req_i.index, or read
//   of the first-edge offset of node req_i.index. Each request gives exactly
//   one response on rsp_o, flagged by done_o for a single cycle.
//   Requests answered without a search (lock, full, out of range, offset
//   of the node one past the last) respond in the cycle after they are
//   taken. Others walk a token down the cell chain one cell per cycle:
//   an insert stops at its sorted position, an edge read at its index,
//   an offset read at its value. busy is high during the walk; the next
//   request may come in the cycle in which the previous response is shown.
//   Configuration: mask at byte address 0, node count at byte address 8,
//   written while no request is in flight.
//   Reset empties the table, clears the read lock and loads the register
//   reset values. The receiver cannot stall; responses are not held.
// ----------------------------------------------------------------------------
module edge_sort_csr_builder_unit #(
  parameter int unsigned MAX_EDGES = esc_pkg::DEF_MAX_EDGES
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire esc_pkg::esc_req_t           req_i,
  output logic                             done_o,
  output esc_pkg::esc_rsp_t                rsp_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [esc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [63:0]                 pwdata,
  output logic      [63:0]                 prdata,
  output logic                             pready
);
  import esc_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_EDGES + 1);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  state_e            state_q;
  esc_req_t          req_q;
  esc_rsp_t          rsp_q;
  logic              done_q;
  logic              lock_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     count_q;

  logic [MASK_W-1:0] mask;
  logic [IDX_W-1:0]  node_count;
  logic [IDX_W-1:0]  nodes;
  esc_ctrl_t         ctrl;
  logic              acc;
  logic              need_walk;
  logic              stop;
  logic              at_end;
  logic              hit_any;
  esc_rsp_t          imm_rsp;
  esc_rsp_t          walk_rsp;
  esc_edge_t         sel_or;

  logic      [MAX_EDGES-1:0] tok_vec;
  logic      [MAX_EDGES-1:0] hit_vec;
  esc_edge_t                 edge_arr [MAX_EDGES];
  esc_edge_t                 sel_arr  [MAX_EDGES];

  esc_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .mask_o       (mask),
    .node_count_o (node_count)
  );

  for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
    logic      tok_left;
    esc_edge_t edge_left;
    if (i == 0) begin : g_head
      assign tok_left  = ctrl.start;
      assign edge_left = ctrl.ins_edge;
    end else begin : g_body
      assign tok_left  = tok_vec[i-1];
      assign edge_left = edge_arr[i-1];
    end
    esc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .tok_left_i  (tok_left),
      .edge_left_i (edge_left),
      .tok_o       (tok_vec[i]),
      .edge_o      (edge_arr[i]),
      .hit_o       (hit_vec[i]),
      .sel_edge_o  (sel_arr[i])
    );
  end

  assign hit_any = |hit_vec;

  always_comb begin
    sel_or = '0;
    for (int i = 0; i < MAX_EDGES; i++) begin
      sel_or = sel_or | sel_arr[i];
    end
  end

  assign busy = (state_q == S_WALK);
  assign acc  = start && !busy;

  assign nodes = (node_count > IDX_W'(MAX_NODES)) ? IDX_W'(MAX_NODES) : node_count;

  // decisions that need no search
  always_comb begin
    imm_rsp            = '0;
    imm_rsp.status     = ST_OK;
    imm_rsp.edge_total = CNT_W'(count_q);
    need_walk          = 1'b0;
    case (req_i.func)
      FUNC_INSERT: begin
        if (lock_q) begin
          imm_rsp.status = ST_LOCKED;
        end else if (count_q >= CW'(MAX_EDGES)) begin
          imm_rsp.status = ST_FULL;
        end else begin
          need_walk = 1'b1;
        end
      end
      FUNC_READ_EDGE: begin
        if (CMPW'(req_i.index) < CMPW'(count_q)) begin
          need_walk = 1'b1;
        end else begin
          imm_rsp.status = ST_RANGE;
        end
      end
      FUNC_READ_OFFSET: begin
        if (req_i.index > nodes) begin
          imm_rsp.status = ST_RANGE;
        end else if (req_i.index == nodes) begin
          imm_rsp.first_offset = CNT_W'(count_q);
        end else begin
          need_walk = 1'b1;
        end
      end
      default: imm_rsp.status = ST_RANGE;
    endcase
  end

  // end of the walk and its answer
  always_comb begin
    at_end             = (cnt_q == count_q);
    walk_rsp           = '0;
    walk_rsp.status    = ST_OK;
    walk_rsp.edge_total = CNT_W'(count_q);
    case (req_q.func)
      FUNC_INSERT: begin
        stop                = at_end || hit_any;
        walk_rsp.edge_total = CNT_W'(CW'(count_q + 1'b1));
      end
      FUNC_READ_EDGE: begin
        stop               = (CMPW'(cnt_q) == CMPW'(req_q.index));
        walk_rsp.edge_src  = sel_or.src;
        walk_rsp.edge_dest = sel_or.dest;
        walk_rsp.edge_sw   = sel_or.sw;
      end
      default: begin
        stop                  = at_end || hit_any;
        walk_rsp.first_offset = CNT_W'(cnt_q);
      end
    endcase
  end

  always_comb begin
    ctrl               = '0;
    ctrl.start         = acc && need_walk;
    ctrl.step          = busy && !stop;
    ctrl.stop          = busy && stop;
    ctrl.place         = busy && stop && (req_q.func == FUNC_INSERT);
    ctrl.func          = req_q.func;
    ctrl.ins_edge.src  = req_q.from_node;
    ctrl.ins_edge.dest = req_q.to_node;
    ctrl.ins_edge.sw   = req_q.switch_id;
    ctrl.idx           = req_q.index;
    ctrl.mask          = mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= '0;
      rsp_q   <= '0;
      done_q  <= 1'b0;
      lock_q  <= 1'b0;
      cnt_q   <= '0;
      count_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            req_q <= req_i;
            if (req_i.func inside {FUNC_READ_EDGE, FUNC_READ_OFFSET}) begin
              lock_q <= 1'b1;
            end
            if (need_walk) begin
              state_q <= S_WALK;
              cnt_q   <= '0;
            end else begin
              rsp_q  <= imm_rsp;
              done_q <= 1'b1;
            end
          end
        end
        S_WALK: begin
          if (stop) begin
            rsp_q   <= walk_rsp;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
            if (req_q.func == FUNC_INSERT) begin
              count_q <= CW'(count_q + 1'b1);
            end
          end else begin
            cnt_q <= CW'(cnt_q + 1'b1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTH
  a_tok_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one search token in the chain");

  a_tok_at_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> ($onehot(tok_vec) || cnt_q == CW'(MAX_EDGES)))
    else $error("walk in progress without a token");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_EDGES))
    else $error("edge count beyond capacity");

  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q |=> lock_q)
    else $error("read lock dropped");

  a_count_grows_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && stop && req_q.func == FUNC_INSERT) |=> (count_q == CW'($past(count_q) + 1'b1)))
    else $error("insert did not grow the table");
`endif

endmodule
`default_nettype wire

/* src/esc_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_cfg: configuration registers
// APB-style access to the configurable switch mask and the node count.
// ----------------------------------------------------------------------------
module esc_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [esc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [63:0]                  pwdata,
  output logic      [63:0]                  prdata,
  output logic                              pready,
  output logic      [esc_pkg::MASK_W-1:0]   mask_o,
  output logic      [esc_pkg::IDX_W-1:0]    node_count_o
);
  import esc_pkg::*;

  logic [MASK_W-1:0] mask_q;
  logic [IDX_W-1:0]  nodes_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= MASK_RESET;
      nodes_q <= NODE_COUNT_RESET;
    end else if (wr_en) begin
      case (paddr[3])
        REG_MASK:  mask_q  <= pwdata;
        REG_NODES: nodes_q <= pwdata[IDX_W-1:0];
        default:   mask_q  <= mask_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_MASK:  prdata = mask_q;
      REG_NODES: prdata = {{(64 - IDX_W){1'b0}}, nodes_q};
      default:   prdata = '0;
    endcase
  end

  assign mask_o       = mask_q;
  assign node_count_o = nodes_q;

endmodule
`default_nettype wire

/* src/esc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esc_cell: one slot of the sorted edge chain
// Holds one edge, the search token and a passed flag; shifts right on insert.
// ----------------------------------------------------------------------------
module esc_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire esc_pkg::esc_ctrl_t ctrl_i,
  input  wire logic               tok_left_i,
  input  wire esc_pkg::esc_edge_t edge_left_i,
  output logic                    tok_o,
  output esc_pkg::esc_edge_t      edge_o,
  output logic                    hit_o,
  output esc_pkg::esc_edge_t      sel_edge_o
);
  import esc_pkg::*;

  logic      tok_q, tok_d;
  logic      passed_q, passed_d;
  esc_edge_t edge_q, edge_d;
  logic      key_gt;
  logic      src_ge;
  logic      cond;

  assign key_gt = edge_key(ctrl_i.mask, edge_q) > edge_key(ctrl_i.mask, ctrl_i.ins_edge);
  assign src_ge = {1'b0, edge_q.src} >= ctrl_i.idx;

  always_comb begin
    case (ctrl_i.func)
      FUNC_INSERT:      cond = key_gt;
      FUNC_READ_OFFSET: cond = src_ge;
      default:          cond = 1'b0;
    endcase
  end

  always_comb begin
    tok_d = tok_q;
    if (ctrl_i.start || ctrl_i.step) begin
      tok_d = tok_left_i;
    end else if (ctrl_i.stop) begin
      tok_d = 1'b0;
    end
  end

  always_comb begin
    passed_d = passed_q;
    if (ctrl_i.start) begin
      passed_d = 1'b0;
    end else if (ctrl_i.step && tok_q) begin
      passed_d = 1'b1;
    end
  end

  // slots before the token keep their edge, slots after it move one right
  always_comb begin
    edge_d = edge_q;
    if (ctrl_i.place) begin
      if (tok_q) begin
        edge_d = ctrl_i.ins_edge;
      end else if (!passed_q) begin
        edge_d = edge_left_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= 1'b0;
      passed_q <= 1'b0;
    end else begin
      tok_q    <= tok_d;
      passed_q <= passed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q <= edge_d;
  end

  assign tok_o      = tok_q;
  assign edge_o     = edge_q;
  assign hit_o      = tok_q && cond;
  assign sel_edge_o = tok_q ? edge_q : '0;

endmodule
`default_nettype wire
